// ===== rtl/pncs_pkg.sv =====
// shared types and constants for the palette nearest colour search block
`timescale 1ns / 1ps

package pncs_pkg;

   localparam int COLOUR_W   = 8;
   localparam int INDEX_W    = 8;
   localparam int WEIGHT_W   = 8;
   localparam int DIST_W     = 34;
   localparam int ENTRY_W    = 3 * COLOUR_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // item operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MATCH_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_RED   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_GREEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_BLUE  = 3'd3;

   // register reset values
   localparam logic                MODE_RESET   = 1'b0;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd16;

   // controller to datapath commands
   typedef struct packed {
      logic req_take;
      logic clear_we;
      logic scan_rd;
      logic load_rsp;
   } pncs_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pipe_empty;
   } pncs_stat_type;

endpackage

// ===== rtl/pncs_if.sv =====
// request, response and register write channel interfaces
`timescale 1ns / 1ps

interface pncs_req_if import pncs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                op;
   logic [INDEX_W-1:0]  entry_index;
   logic [COLOUR_W-1:0] red;
   logic [COLOUR_W-1:0] green;
   logic [COLOUR_W-1:0] blue;

   modport source (output valid, op, entry_index, red, green, blue, input ready);
   modport sink (input valid, op, entry_index, red, green, blue, output ready);
endinterface

interface pncs_rsp_if import pncs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] nearest_index;
   logic               exact_match;
   logic [DIST_W-1:0]  best_distance;

   modport source (output valid, nearest_index, exact_match, best_distance, input ready);
   modport sink (input valid, nearest_index, exact_match, best_distance, output ready);
endinterface

interface pncs_csr_if import pncs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/pncs_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pncs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pncs_datapath.sv =====
// palette store, distance pipeline, best tracking and result register
`timescale 1ns / 1ps

module pncs_datapath import pncs_pkg::*; #(
   parameter int ENTRIES = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pncs_cmd_type                 cmd,
   input  logic [$clog2(ENTRIES)-1:0]   addr,
   input  logic                         req_op,
   input  logic [INDEX_W-1:0]           req_entry_index,
   input  logic [COLOUR_W-1:0]          req_red,
   input  logic [COLOUR_W-1:0]          req_green,
   input  logic [COLOUR_W-1:0]          req_blue,
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data,
   output pncs_stat_type                stat,
   output logic [INDEX_W-1:0]           rsp_nearest_index,
   output logic                         rsp_exact_match,
   output logic [DIST_W-1:0]            rsp_best_distance
);

   localparam int AW     = $clog2(ENTRIES);
   localparam int RW     = AW + 1;
   localparam int STEP_Q = 255 / ENTRIES;
   localparam int STEP_R = 255 % ENTRIES;

   function automatic logic [COLOUR_W-1:0] abs_diff(input logic [COLOUR_W-1:0] a,
                                                     input logic [COLOUR_W-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

   // register file
   logic                mode_ff,  mode_in;
   logic [WEIGHT_W-1:0] wred_ff,  wred_in;
   logic [WEIGHT_W-1:0] wgrn_ff,  wgrn_in;
   logic [WEIGHT_W-1:0] wblu_ff,  wblu_in;

   always_comb begin
      mode_in = mode_ff;
      wred_in = wred_ff;
      wgrn_in = wgrn_ff;
      wblu_in = wblu_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MATCH_MODE:   mode_in = csr_data[0];
            REG_WEIGHT_RED:   wred_in = csr_data;
            REG_WEIGHT_GREEN: wgrn_in = csr_data;
            REG_WEIGHT_BLUE:  wblu_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         wred_ff <= WEIGHT_RESET;
         wgrn_ff <= WEIGHT_RESET;
         wblu_ff <= WEIGHT_RESET;
      end else begin
         mode_ff <= mode_in;
         wred_ff <= wred_in;
         wgrn_ff <= wgrn_in;
         wblu_ff <= wblu_in;
      end
   end

   // greyscale ramp: quotient and remainder of i*255/ENTRIES, stepped per entry
   logic [COLOUR_W-1:0] ramp_q_ff, ramp_q_in;
   logic [RW-1:0]       ramp_r_ff, ramp_r_in;
   logic [RW-1:0]       ramp_sum;

   always_comb begin
      ramp_sum  = ramp_r_ff + RW'(STEP_R);
      ramp_q_in = ramp_q_ff;
      ramp_r_in = ramp_r_ff;
      if (cmd.clear_we) begin
         if (ramp_sum >= RW'(ENTRIES)) begin
            ramp_r_in = ramp_sum - RW'(ENTRIES);
            ramp_q_in = ramp_q_ff + COLOUR_W'(STEP_Q) + COLOUR_W'(1);
         end else begin
            ramp_r_in = ramp_sum;
            ramp_q_in = ramp_q_ff + COLOUR_W'(STEP_Q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_q_ff <= '0;
         ramp_r_ff <= '0;
      end else begin
         ramp_q_ff <= ramp_q_in;
         ramp_r_ff <= ramp_r_in;
      end
   end

   // request capture
   logic                op_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [COLOUR_W-1:0] qred_ff, qgrn_ff, qblu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_WRITE;
      end else if (cmd.req_take) begin
         op_ff <= req_op;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         idx_ff  <= req_entry_index;
         qred_ff <= req_red;
         qgrn_ff <= req_green;
         qblu_ff <= req_blue;
      end
   end

   // palette store
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic [ENTRY_W-1:0]  ram_rdata;
   logic                wr_hit;

   assign wr_hit = cmd.req_take && (req_op == OP_WRITE)
                   && (32'(req_entry_index) < 32'(ENTRIES));
   assign ram_we    = cmd.clear_we || wr_hit;
   assign ram_waddr = cmd.clear_we ? addr : AW'(req_entry_index);
   assign ram_wdata = cmd.clear_we ? {ramp_q_ff, ramp_q_ff, ramp_q_ff}
                                   : {req_red, req_green, req_blue};

   pncs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_palette (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (cmd.scan_rd),
      .raddr (addr),
      .rdata (ram_rdata)
   );

   // distance pipeline
   logic                rd_v_ff, p_v_ff, sq_v_ff, dist_v_ff;
   logic [AW-1:0]       rd_i_ff, p_i_ff, sq_i_ff, dist_i_ff;
   logic [15:0]         pr_ff, pg_ff, pb_ff;
   logic [31:0]         sr_ff, sg_ff, sb_ff;
   logic [DIST_W-1:0]   dist_ff;
   logic [COLOUR_W-1:0] dr, dg, db;
   logic [15:0]         pr_in, pg_in, pb_in;

   always_comb begin
      dr = abs_diff(qred_ff, ram_rdata[23:16]);
      dg = abs_diff(qgrn_ff, ram_rdata[15:8]);
      db = abs_diff(qblu_ff, ram_rdata[7:0]);
      if (mode_ff) begin
         pr_in = 16'(dr) * 16'(wred_ff);
         pg_in = 16'(dg) * 16'(wgrn_ff);
         pb_in = 16'(db) * 16'(wblu_ff);
      end else begin
         pr_in = 16'(dr);
         pg_in = 16'(dg);
         pb_in = 16'(db);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         p_v_ff    <= 1'b0;
         sq_v_ff   <= 1'b0;
         dist_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.scan_rd;
         p_v_ff    <= rd_v_ff;
         sq_v_ff   <= p_v_ff;
         dist_v_ff <= sq_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_i_ff   <= addr;
      p_i_ff    <= rd_i_ff;
      sq_i_ff   <= p_i_ff;
      dist_i_ff <= sq_i_ff;
      pr_ff     <= pr_in;
      pg_ff     <= pg_in;
      pb_ff     <= pb_in;
      sr_ff     <= 32'(pr_ff) * 32'(pr_ff);
      sg_ff     <= 32'(pg_ff) * 32'(pg_ff);
      sb_ff     <= 32'(pb_ff) * 32'(pb_ff);
      dist_ff   <= DIST_W'(sr_ff) + DIST_W'(sg_ff) + DIST_W'(sb_ff);
   end

   // running minimum, entry zero seeds it
   logic [DIST_W-1:0] best_d_ff;
   logic [AW-1:0]     best_i_ff;

   always_ff @(posedge clock) begin
      if (dist_v_ff && ((dist_i_ff == '0) || (dist_ff < best_d_ff))) begin
         best_d_ff <= dist_ff;
         best_i_ff <= dist_i_ff;
      end
   end

   assign stat.pipe_empty = !(rd_v_ff || p_v_ff || sq_v_ff || dist_v_ff);

   // result register
   logic [INDEX_W-1:0] rsp_index_ff;
   logic               rsp_exact_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         if (op_ff == OP_QUERY) begin
            rsp_index_ff <= INDEX_W'(best_i_ff);
            rsp_exact_ff <= (best_d_ff == '0);
            rsp_dist_ff  <= best_d_ff;
         end else begin
            rsp_index_ff <= idx_ff;
            rsp_exact_ff <= 1'b0;
            rsp_dist_ff  <= '0;
         end
      end
   end

   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_exact_match   = rsp_exact_ff;
   assign rsp_best_distance = rsp_dist_ff;

endmodule

// ===== rtl/pncs_ctrl.sv =====
// controller: clearing pass, scan sequencing and response handshake
`timescale 1ns / 1ps

module pncs_ctrl import pncs_pkg::*; #(
   parameter int ENTRIES = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_op,
   output logic                       req_ready,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   input  pncs_stat_type              stat,
   output pncs_cmd_type               cmd,
   output logic [$clog2(ENTRIES)-1:0] addr
);

   localparam int AW = $clog2(ENTRIES);
   localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_we = 1'b1;
            cnt_in       = cnt_ff + AW'(1);
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.req_take = 1'b1;
               cnt_in       = '0;
               state_in     = (req_op == OP_QUERY) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            cnt_in      = cnt_ff + AW'(1);
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (stat.pipe_empty) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign addr      = cnt_ff;

endmodule

// ===== rtl/palette_nearest_colour_search.sv =====
// top level of the palette nearest colour search block
//
//   channel   dir   payload                                          transfer when
//   req_ch    in    op, entry_index, red, green, blue                valid & ready
//   rsp_ch    out   nearest_index, exact_match, best_distance        valid & ready
//   csr_ch    in    index (0 mode, 1..3 red/green/blue weight), data valid & ready
//
// after a request transfer a write goes straight to loading its response, while for a
// query the single palette read port first scans one entry a cycle into a four stage
// distance pipeline, then drains and loads the result; a loaded response goes valid
// in the same cycle that the controller is ready to take the next request
// after reset a clearing pass writes the greyscale ramp into every entry; req is not
// ready during it, register writes are taken at any time
// the response sits in an output register, so a new request is taken while it waits;
// a finished item stalls only when the previous response is still not taken
`timescale 1ns / 1ps

module palette_nearest_colour_search import pncs_pkg::*; #(
   parameter int ENTRIES = 256
) (
   input  logic       clock,
   input  logic       reset,
   pncs_req_if.sink   req_ch,
   pncs_rsp_if.source rsp_ch,
   pncs_csr_if.sink   csr_ch
);

   localparam int AW = $clog2(ENTRIES);

   pncs_cmd_type  cmd;
   pncs_stat_type stat;
   logic [AW-1:0] addr;

   // register writes never stall
   assign csr_ch.ready = 1'b1;

   // sequencing: clearing pass, palette scan, response hand-off
   pncs_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .stat      (stat),
      .cmd       (cmd),
      .addr      (addr)
   );

   // palette memory, weights, distance pipeline and result register
   pncs_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .addr              (addr),
      .req_op            (req_ch.op),
      .req_entry_index   (req_ch.entry_index),
      .req_red           (req_ch.red),
      .req_green         (req_ch.green),
      .req_blue          (req_ch.blue),
      .csr_we            (csr_ch.valid && csr_ch.ready),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .stat              (stat),
      .rsp_nearest_index (rsp_ch.nearest_index),
      .rsp_exact_match   (rsp_ch.exact_match),
      .rsp_best_distance (rsp_ch.best_distance)
   );

   // a response only appears after the controller loaded the result register
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_ch.valid) |-> $past(cmd.load_rsp))
      else $error("response raised without a result load");

   // the result is never taken while distances are still in flight
   a_load_when_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.pipe_empty)
      else $error("result loaded with scan pipeline busy");

   // an exact match always carries a zero distance
   a_exact_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.exact_match |-> rsp_ch.best_distance == '0)
      else $error("exact match with nonzero distance");

   // a query transfer blocks further requests while the scan runs
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready && req_ch.op == OP_QUERY |=> !req_ch.ready)
      else $error("request taken during a scan");

endmodule
